/* rtl/duer_pkg.sv */
// Package for the dual ultrasonic echo ranger: shared widths, codes and the
// fixed-point scaling constant. No dependencies.
`default_nettype none

package duer_pkg;

  localparam int TimeW = 16;  // capture and counter-top width
  localparam int DistW = 12;  // distance width in cm
  localparam int SpanW = TimeW + 1;  // elapsed ticks, top + stop may carry

  // cm = floor(ticks * 17 / 1000) computed as (ticks * CmRecip) >> CmShift,
  // CmRecip = 17 * ceil(2^32 / 1000). Exact for every span below 2^17.
  localparam int CmShift = 32;
  localparam int RecipW  = 27;
  localparam logic [RecipW-1:0] CmRecip = 27'd73014456;
  localparam int ProdW   = SpanW + RecipW;

  typedef enum logic {
    OP_CAPTURE = 1'b0,
    OP_PERIOD  = 1'b1
  } op_t;

  localparam logic SENSOR_LEFT  = 1'b0;
  localparam logic SENSOR_RIGHT = 1'b1;

  localparam logic [0:0] CFG_COUNTER_TOP  = 1'b0;
  localparam logic [0:0] CFG_TIMEOUT_DIST = 1'b1;

  localparam logic [DistW-1:0] TimeoutDistRst = 12'd500;
  localparam logic [TimeW-1:0] CounterTopRst  = 16'hFFFF;

endpackage : duer_pkg

`default_nettype wire

/* rtl/dual_ultrasonic_echo_ranger_core.sv */
// Top level of the dual ultrasonic echo ranger: input register, span unit,
// sensor state and result register. Depends on duer_pkg and duer_span_cm.
`default_nettype none

// Ranges a left and a right ultrasonic sensor from pairs of timer captures.
// Each input word is either a capture (op = 0, sensor_sel names the sensor,
// capture_value the timer count) or a period tick (op = 1). The first
// capture of a sensor stores its start time and arms it; the second takes
// the elapsed ticks (wrap through counter_top when stop <= start) and stores
// floor(ticks * 17 / 1000) cm, then disarms. A period tick hands over to the
// other sensor; an outgoing sensor still armed gets timeout_distance. Every
// word yields one result word with both distances, the active sensor and an
// updated flag. Throughput is one word per clock unless the result stalls;
// a word passes the input register, then the span and scaling path
// (subtract, compare and one 17 x 27 multiply) into the result register.
// The distance registers are the result register: they only change when a
// result word is loaded. Configuration is written through cfg_we/cfg_index/
// cfg_wdata while the block is idle, a rule on the user that the block
// does not enforce. Capture values use their low TIMER_BITS bits.

module dual_ultrasonic_echo_ranger_core import duer_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // config
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [TimeW-1:0] cfg_wdata,
  // input words
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_op,
  input  wire logic             in_sensor_sel,
  input  wire logic [TimeW-1:0] in_capture_value,
  // result words
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [DistW-1:0] out_distance_left,
  output logic      [DistW-1:0] out_distance_right,
  output logic                  out_active_sensor,
  output logic                  out_distance_updated
);

  // Capture bits above the timer width are dropped.
  localparam logic [TimeW-1:0] CapMask =
    (TIMER_BITS >= TimeW) ? {TimeW{1'b1}} : TimeW'((64'd1 << TIMER_BITS) - 64'd1);

  // config registers
  logic [TimeW-1:0] counter_top_r;
  logic [DistW-1:0] timeout_dist_r;

  // input register
  logic             in_valid_r;
  op_t              op_r;
  logic             sel_r;
  logic [TimeW-1:0] cap_r;

  // sensor state, doubles as result payload
  logic [TimeW-1:0] start_r   [2];
  logic [TimeW-1:0] start_nxt [2];
  logic [1:0]       armed_r;
  logic [1:0]       armed_nxt;
  logic [DistW-1:0] dist_r    [2];
  logic [DistW-1:0] dist_nxt  [2];
  logic             cur_r;
  logic             cur_nxt;

  // result control
  logic             out_valid_r;
  logic             updated_r;
  logic             updated_nxt;

  logic             advance;
  logic [DistW-1:0] span_cm;

  // Input register moves on when the result slot is free or being taken.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_top_r  <= CounterTopRst;
      timeout_dist_r <= TimeoutDistRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNTER_TOP:  counter_top_r  <= cfg_wdata;
        CFG_TIMEOUT_DIST: timeout_dist_r <= cfg_wdata[DistW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= op_t'(in_op);
      sel_r <= in_sensor_sel;
      cap_r <= in_capture_value & CapMask;
    end
  end

  duer_span_cm u_span (
    .start_time  (start_r[sel_r]),
    .stop_time   (cap_r),
    .counter_top (counter_top_r),
    .distance_cm (span_cm)
  );

  // Next sensor state for the word in the input register.
  always_comb begin
    start_nxt   = start_r;
    armed_nxt   = armed_r;
    dist_nxt    = dist_r;
    cur_nxt     = cur_r;
    updated_nxt = 1'b0;
    case (op_r)
      OP_CAPTURE: begin
        if (!armed_r[sel_r]) begin
          start_nxt[sel_r] = cap_r;   // echo start: arm
          armed_nxt[sel_r] = 1'b1;
        end else begin
          dist_nxt[sel_r]  = span_cm; // echo end: measure, disarm
          armed_nxt[sel_r] = 1'b0;
          updated_nxt      = 1'b1;
        end
      end
      OP_PERIOD: begin
        if (armed_r[cur_r]) begin
          dist_nxt[cur_r] = timeout_dist_r;  // no echo end seen
          updated_nxt     = 1'b1;
        end
        armed_nxt[cur_r] = 1'b0;
        cur_nxt          = ~cur_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '{default: '0};
      armed_r     <= '0;
      dist_r      <= '{default: '0};
      cur_r       <= SENSOR_LEFT;
      out_valid_r <= 1'b0;
      updated_r   <= 1'b0;
    end else begin
      if (advance) begin
        start_r     <= start_nxt;
        armed_r     <= armed_nxt;
        dist_r      <= dist_nxt;
        cur_r       <= cur_nxt;
        updated_r   <= updated_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_distance_left    = dist_r[SENSOR_LEFT];
  assign out_distance_right   = dist_r[SENSOR_RIGHT];
  assign out_active_sensor    = cur_r;
  assign out_distance_updated = updated_r;

  // A period word always hands measurement to the other sensor.
  a_period_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && op_r == OP_PERIOD) |=> (out_active_sensor != $past(cur_r)))
    else $error("active sensor did not toggle on period word");

  // An echo end clears the arm bit and flags an update.
  a_echo_end_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && op_r == OP_CAPTURE && armed_r[sel_r])
      |=> (!armed_r[$past(sel_r)] && out_distance_updated))
    else $error("echo end left sensor armed or unflagged");

  // A held input word is not lost while the result slot is blocked.
  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("input register dropped a word");

  // Distances only change when a result word is loaded.
  a_dist_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(out_distance_left) && $stable(out_distance_right)))
    else $error("distance changed without a result word");

endmodule : dual_ultrasonic_echo_ranger_core

`default_nettype wire

/* rtl/duer_span_cm.sv */
// Echo span to distance: wrap-aware tick difference and constant scaling.
// Depends on duer_pkg.
`default_nettype none

module duer_span_cm import duer_pkg::*; (
  input  wire logic [TimeW-1:0] start_time,
  input  wire logic [TimeW-1:0] stop_time,
  input  wire logic [TimeW-1:0] counter_top,
  output logic      [DistW-1:0] distance_cm
);

  logic [SpanW-1:0] top_plus;
  logic [SpanW-1:0] start_ext;
  logic [SpanW-1:0] ticks;
  logic [ProdW-1:0] prod;

  assign top_plus  = {1'b0, counter_top} + {1'b0, stop_time};
  assign start_ext = {1'b0, start_time};

  always_comb begin
    if (start_time < stop_time) begin
      ticks = {1'b0, stop_time - start_time};
    end else if (top_plus >= start_ext) begin
      ticks = top_plus - start_ext;
    end else begin
      ticks = '0;  // wrapped span below zero saturates
    end
  end

  // Product never exceeds 1114 cm after the shift, so the top bits fit without clipping.
  assign prod        = ProdW'(ticks) * ProdW'(CmRecip);
  assign distance_cm = prod[CmShift +: DistW];

endmodule : duer_span_cm

`default_nettype wire

/* tb/duer_range_checker.sv */
// Scoreboard for the dual ultrasonic echo ranger: tracks register writes and
// input words, predicts each result word and compares it. Depends on duer_pkg.
`timescale 1ns / 1ps

module duer_range_checker import duer_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [TimeW-1:0] cfg_wdata,
  input  wire logic             in_valid,
  input  wire logic             in_ready,
  input  wire logic             in_op,
  input  wire logic             in_sensor_sel,
  input  wire logic [TimeW-1:0] in_capture_value,
  input  wire logic             out_valid,
  input  wire logic             out_ready,
  input  wire logic [DistW-1:0] out_distance_left,
  input  wire logic [DistW-1:0] out_distance_right,
  input  wire logic             out_active_sensor,
  input  wire logic             out_distance_updated,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct packed {
    logic [DistW-1:0] left_cm;
    logic [DistW-1:0] right_cm;
    logic             active;
    logic             updated;
  } range_word_t;

  // shadow of the ranger
  logic [TimeW-1:0] top_count   = CounterTopRst;
  logic [DistW-1:0] timeout_cm  = TimeoutDistRst;
  logic [TimeW-1:0] echo_start [2];
  logic             echo_armed [2];
  logic [DistW-1:0] range_cm   [2];
  logic             active_side = SENSOR_LEFT;

  range_word_t expected_ranges [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    for (int s = 0; s < 2; s++) begin
      echo_start[s] = '0;
      echo_armed[s] = 1'b0;
      range_cm[s]   = '0;
    end
  end

  task automatic report_fault(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic logic [DistW-1:0] ticks_to_cm(input logic [SpanW-1:0] ticks);
    int unsigned cm;
    cm = ticks;
    cm = (cm * 17) / 1000;
    return (cm > 4095) ? {DistW{1'b1}} : cm[DistW-1:0];
  endfunction

  task automatic step_ranger(input logic op, input logic sel,
                             input logic [TimeW-1:0] cap, output range_word_t word);
    logic [SpanW-1:0] ticks;
    logic [SpanW-1:0] top_plus;
    logic             side;
    logic             upd;
    upd = 1'b0;
    if (op_t'(op) == OP_CAPTURE) begin
      if (!echo_armed[sel]) begin
        echo_start[sel] = cap;
        echo_armed[sel] = 1'b1;
      end else begin
        if (echo_start[sel] < cap) begin
          ticks = {1'b0, cap} - {1'b0, echo_start[sel]};
        end else begin
          // wrap through the counter top; clamp when it would go negative
          top_plus = {1'b0, top_count} + {1'b0, cap};
          ticks = (top_plus >= {1'b0, echo_start[sel]}) ?
                  top_plus - {1'b0, echo_start[sel]} : '0;
        end
        range_cm[sel]   = ticks_to_cm(ticks);
        echo_armed[sel] = 1'b0;
        upd = 1'b1;
      end
    end else begin
      side = active_side;
      if (echo_armed[side]) begin
        range_cm[side] = timeout_cm;
        upd = 1'b1;
      end
      echo_armed[side] = 1'b0;
      active_side = ~side;
    end
    word.left_cm  = range_cm[SENSOR_LEFT];
    word.right_cm = range_cm[SENSOR_RIGHT];
    word.active   = active_side;
    word.updated  = upd;
  endtask

  always @(posedge clk) begin
    range_word_t want;
    if (!rst_n) begin
      top_count   = CounterTopRst;
      timeout_cm  = TimeoutDistRst;
      active_side = SENSOR_LEFT;
      for (int s = 0; s < 2; s++) begin
        echo_start[s] = '0;
        echo_armed[s] = 1'b0;
        range_cm[s]   = '0;
      end
      expected_ranges.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COUNTER_TOP:  top_count  = cfg_wdata;
          CFG_TIMEOUT_DIST: timeout_cm = cfg_wdata[DistW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        step_ranger(in_op, in_sensor_sel, in_capture_value, want);
        expected_ranges.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_ranges.size() == 0) begin
          report_fault("result word with none pending", out_distance_left, 0);
        end else begin
          want = expected_ranges.pop_front();
          if (out_distance_left !== want.left_cm)
            report_fault("distance_left", out_distance_left, want.left_cm);
          if (out_distance_right !== want.right_cm)
            report_fault("distance_right", out_distance_right, want.right_cm);
          if (out_active_sensor !== want.active)
            report_fault("active_sensor", out_active_sensor, want.active);
          if (out_distance_updated !== want.updated)
            report_fault("distance_updated", out_distance_updated, want.updated);
        end
      end
    end
    outstanding <= expected_ranges.size();
  end

endmodule : duer_range_checker

/* tb/tb_dual_ultrasonic_echo_ranger_core.sv */
// Testbench top for the dual ultrasonic echo ranger: clock, reset, register
// writes, input and result traffic, verdict. Depends on duer_pkg, the core
// and duer_range_checker.
`timescale 1ns / 1ps

module tb_dual_ultrasonic_echo_ranger_core import duer_pkg::*;;

  logic             clk   = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [0:0]       cfg_index = CFG_COUNTER_TOP;
  logic [TimeW-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic             in_op            = OP_CAPTURE;
  logic             in_sensor_sel    = SENSOR_LEFT;
  logic [TimeW-1:0] in_capture_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [DistW-1:0] out_distance_left;
  logic [DistW-1:0] out_distance_right;
  logic             out_active_sensor;
  logic             out_distance_updated;

  int fail_count;
  int outstanding;

  // sender pacing and bookkeeping
  int words_sent    = 0;
  int settings_done = 0;
  int burst_left    = 1;
  int burst_max     = 24;

  // hold-off requests from the stimulus; the receiver counts them out itself
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_cycle  = 0;

  always #10 clk = ~clk;

  dual_ultrasonic_echo_ranger_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_sensor_sel        (in_sensor_sel),
    .in_capture_value     (in_capture_value),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_distance_left    (out_distance_left),
    .out_distance_right   (out_distance_right),
    .out_active_sensor    (out_active_sensor),
    .out_distance_updated (out_distance_updated)
  );

  duer_range_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_sensor_sel        (in_sensor_sel),
    .in_capture_value     (in_capture_value),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_distance_left    (out_distance_left),
    .out_distance_right   (out_distance_right),
    .out_active_sensor    (out_active_sensor),
    .out_distance_updated (out_distance_updated),
    .fail_count           (fail_count),
    .outstanding          (outstanding)
  );

  // Receiver: a long hold-off when asked, otherwise a stall pattern that
  // rotates (always ready, coin toss, one in three, mostly ready).
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= 60;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 400) % 4)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= (rx_cycle % 3 == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Present one word and hold it until the core takes it.
  task automatic offer_word(input op_t op, input logic sel, input logic [TimeW-1:0] cap);
    in_valid         <= 1'b1;
    in_op            <= op;
    in_sensor_sel    <= sel;
    in_capture_value <= cap;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Burst bookkeeping after each accepted word. Valid only drops when a
  // real gap follows, so it is never lowered and raised in one step.
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_paced(input op_t op, input logic sel, input logic [TimeW-1:0] cap);
    offer_word(op, sel, cap);
    pace_sender();
  endtask

  // Stop sending and wait for every pending result word. The checker's
  // count is registered and trails the traffic, hence a clock edge first.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Both registers, back to back; timeout gets junk in the unused top bits.
  task automatic write_settings(input logic [TimeW-1:0] top, input logic [DistW-1:0] tmo);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COUNTER_TOP;
    cfg_wdata <= top;
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_DIST;
    cfg_wdata <= {4'($urandom_range(0, 15)), tmo};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // Capture values lean towards both ends of the timer so wraps and
  // equal start/stop pairs turn up often.
  function automatic logic [TimeW-1:0] pick_capture();
    case ($urandom_range(0, 3))
      0:       return TimeW'($urandom_range(0, 15));
      1:       return TimeW'($urandom_range(65520, 65535));
      default: return TimeW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly captures, which pair up per sensor into arm/measure sequences,
  // with period ticks mixed in so some sensors get handed over while armed.
  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 15)
        send_paced(OP_PERIOD, 1'($urandom_range(0, 1)), TimeW'($urandom));
      else
        send_paced(OP_CAPTURE, 1'($urandom_range(0, 1)), pick_capture());
    end
    wait_all_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset values
    write_settings(CounterTopRst, TimeoutDistRst);
    send_paced(OP_PERIOD,  SENSOR_LEFT,  16'h0000);  // hand-over, nothing armed
    send_paced(OP_CAPTURE, SENSOR_LEFT,  16'd100);   // capture on the idle sensor
    send_paced(OP_CAPTURE, SENSOR_LEFT,  16'd59000); // plain span
    send_paced(OP_CAPTURE, SENSOR_RIGHT, 16'hFFFF);
    send_paced(OP_CAPTURE, SENSOR_RIGHT, 16'h0000);  // wrap, zero ticks
    send_paced(OP_CAPTURE, SENSOR_RIGHT, 16'd500);
    send_paced(OP_CAPTURE, SENSOR_RIGHT, 16'd500);   // stop equals start: full wrap
    send_paced(OP_CAPTURE, SENSOR_RIGHT, 16'h0000);
    send_paced(OP_CAPTURE, SENSOR_RIGHT, 16'hFFFF);  // longest direct span
    send_paced(OP_CAPTURE, SENSOR_LEFT,  16'd1);
    send_paced(OP_CAPTURE, SENSOR_LEFT,  16'h0000);  // wrapped span one tick short of full
    send_paced(OP_CAPTURE, SENSOR_RIGHT, 16'd10);
    send_paced(OP_PERIOD,  SENSOR_LEFT,  16'hFFFF);  // right armed: timeout
    send_paced(OP_CAPTURE, SENSOR_LEFT,  16'd7);
    send_paced(OP_PERIOD,  SENSOR_RIGHT, 16'h5A5A);  // left armed: timeout
    send_paced(OP_PERIOD,  SENSOR_RIGHT, 16'hA5A5);  // nothing armed
    wait_all_results();

    // counter top of zero: wrapped spans that would go below zero clamp
    write_settings(16'h0000, 12'hFFF);
    send_paced(OP_CAPTURE, SENSOR_LEFT,  16'd1000);
    send_paced(OP_CAPTURE, SENSOR_LEFT,  16'd5);
    send_paced(OP_CAPTURE, SENSOR_RIGHT, 16'h0000);
    send_paced(OP_CAPTURE, SENSOR_RIGHT, 16'h0000);
    send_paced(OP_CAPTURE, SENSOR_LEFT,  16'd3);
    send_paced(OP_PERIOD,  SENSOR_LEFT,  16'd0);     // timeout of 4095
    wait_all_results();

    // Random phases. The first one opens with a long receiver hold-off while
    // long bursts keep the input full, so the core has to back-pressure.
    write_settings(CounterTopRst, TimeoutDistRst);
    burst_max = 200;
    hold_asks <= hold_asks + 1;
    run_random(100);
    burst_max = 24;

    write_settings(16'h0000, 12'hFFF);
    run_random(100);
    write_settings(16'hFFFF, 12'h000);
    run_random(100);
    write_settings(16'd1000, 12'd123);
    run_random(100);
    write_settings(TimeW'($urandom), DistW'($urandom));
    run_random(100);
    burst_max = 400;  // long bursts, so the sender seldom idles
    write_settings(16'h8000, 12'hFFF);
    run_random(100);
    burst_max = 24;
    write_settings(TimeW'($urandom), DistW'($urandom));
    run_random(100);

    repeat (8) @(posedge clk);
    $display("Covered %0d words over %0d register settings: spans, wraps, clamped wraps,",
             words_sent, settings_done);
    $display("hand-overs with and without timeouts, under stalls and back-pressure.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule : tb_dual_ultrasonic_echo_ranger_core

/* filelist.f */
rtl/duer_pkg.sv
rtl/duer_span_cm.sv
rtl/dual_ultrasonic_echo_ranger_core.sv
tb/duer_range_checker.sv
tb/tb_dual_ultrasonic_echo_ranger_core.sv
